// ===== src/acsc_pkg.sv =====
// Shared types and constants for the ADC channel scan conditioner.
// No dependencies; every other file refers to it by scoped names.
package acsc_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CODE_W     = 15;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned AXIS_W     = 8;
  localparam int unsigned FILT_W     = 24;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned DBAND_W    = 7;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Joystick scaling: (code - offset) / 132, done as (x >> 2) * 1986 >> 16.
  localparam logic [16:0] AXIS_OFFSET = 17'd13200;
  localparam logic [10:0] AXIS_RECIP  = 11'd1986;
  localparam logic [6:0]  AXIS_LIMIT  = 7'd100;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;
  localparam logic [FILT_W-1:0]   FILT_RESET   = 24'd3225600;   // 12600 mV, 8 fraction bits
  localparam logic [15:0]         START_BASE   = 16'hC3E3;

  localparam logic [DBAND_W-1:0]  DBAND_RESET  = 7'd8;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd38;
  localparam logic [MV_W-1:0]     FLOOR_RESET  = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND    = 2'd0,
    CFG_NEW_WEIGHT  = 2'd1,
    CFG_BATT_FLOOR  = 2'd2
  } cfg_idx_t;

  typedef enum logic [CHAN_W-1:0] {
    CH_JOY_X = 2'd0,
    CH_JOY_Y = 2'd1,
    CH_BATT  = 2'd2,
    CH_AUX   = 2'd3
  } chan_t;

  typedef struct packed {
    logic [DBAND_W-1:0]  deadband;
    logic [WEIGHT_W-1:0] new_weight;
    logic [MV_W-1:0]     battery_floor_mv;
  } cfg_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic [FILT_W-1:0]        battery_filter;
    logic [CODE_W-1:0]        aux_level;
  } scan_state_t;

endpackage

// ===== src/acsc_if.sv =====
// Valid/ready channel interfaces for sample, result and register-write beats.
// Depends on acsc_pkg for field widths.
interface acsc_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [acsc_pkg::SAMPLE_W-1:0]      sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface acsc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [acsc_pkg::CHAN_W-1:0]           channel_done;
  logic signed [acsc_pkg::AXIS_W-1:0]    joy_x;
  logic signed [acsc_pkg::AXIS_W-1:0]    joy_y;
  logic [acsc_pkg::MV_W-1:0]             supply_mv;
  logic [acsc_pkg::CODE_W-1:0]           aux_code;
  logic [15:0]                           start_word;
  modport source (output valid, output channel_done, output joy_x, output joy_y,
                  output supply_mv, output aux_code, output start_word, input ready);
  modport sink   (input valid, input channel_done, input joy_x, input joy_y,
                  input supply_mv, input aux_code, input start_word, output ready);
endinterface

interface acsc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [acsc_pkg::CFG_IDX_W-1:0]      index;
  logic [acsc_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/acsc_cond.sv =====
// Per-sample conditioning: joystick scaling with clamp and deadband,
// battery floor and low-pass update, aux capture. Depends on acsc_pkg.
module acsc_cond (
  input  logic signed [acsc_pkg::SAMPLE_W-1:0] sample,
  input  logic [acsc_pkg::CHAN_W-1:0]          channel,
  input  acsc_pkg::cfg_t                       cfg,
  input  acsc_pkg::scan_state_t                state,
  output acsc_pkg::scan_state_t                state_nxt
);

  logic [acsc_pkg::CODE_W-1:0]   code;
  logic signed [16:0]            diff;
  logic                          diff_neg;
  logic [16:0]                   diff_abs;
  logic [23:0]                   quot_prod;
  logic [7:0]                    quot_mag;
  logic [6:0]                    quot_clamp;
  logic signed [acsc_pkg::AXIS_W-1:0] axis_val;
  logic [18:0]                   code_x11;
  logic [18:0]                   floor_x8;
  logic [23:0]                   v256;
  logic [acsc_pkg::WEIGHT_W-1:0] w_sat;
  logic [acsc_pkg::WEIGHT_W-1:0] w_old;
  logic [32:0]                   old_term;
  logic [32:0]                   new_term;
  logic [33:0]                   acc;
  logic [acsc_pkg::FILT_W-1:0]   filt_new;

  // Negative conversions count as zero.
  assign code = sample[acsc_pkg::SAMPLE_W-1] ? '0 : sample[acsc_pkg::CODE_W-1:0];

  // Truncating division by 132 on the magnitude: drop two bits, then /33 by reciprocal.
  assign diff      = $signed({2'b00, code}) - $signed(acsc_pkg::AXIS_OFFSET);
  assign diff_neg  = diff[16];
  assign diff_abs  = diff_neg ? 17'(-diff) : 17'(diff);
  assign quot_prod = 24'(diff_abs[14:2]) * 24'(acsc_pkg::AXIS_RECIP);
  assign quot_mag  = quot_prod[23:16];

  always_comb begin
    quot_clamp = (quot_mag > 8'(acsc_pkg::AXIS_LIMIT)) ? acsc_pkg::AXIS_LIMIT
                                                       : quot_mag[6:0];
    if (quot_clamp < cfg.deadband) begin
      quot_clamp = '0;
    end
    axis_val = diff_neg ? -$signed({1'b0, quot_clamp}) : $signed({1'b0, quot_clamp});
  end

  // Battery: v in 1/256 mV is code*352; floor test is code*11 < floor*8.
  assign code_x11 = 19'(code) * 19'd11;
  assign floor_x8 = {cfg.battery_floor_mv, 3'b000};
  assign v256     = (code_x11 < floor_x8) ? '0 : {code_x11, 5'b00000};
  assign w_sat    = (cfg.new_weight > acsc_pkg::WEIGHT_FULL) ? acsc_pkg::WEIGHT_FULL
                                                             : cfg.new_weight;
  assign w_old    = acsc_pkg::WEIGHT_FULL - w_sat;
  assign old_term = 33'(state.battery_filter) * 33'(w_old);
  assign new_term = 33'(v256) * 33'(w_sat);
  assign acc      = 34'(old_term) + 34'(new_term);
  assign filt_new = acc[31:8];

  always_comb begin
    state_nxt = state;
    case (acsc_pkg::chan_t'(channel))
      acsc_pkg::CH_JOY_X: state_nxt.axis_x         = axis_val;
      acsc_pkg::CH_JOY_Y: state_nxt.axis_y         = axis_val;
      acsc_pkg::CH_BATT:  state_nxt.battery_filter = filt_new;
      acsc_pkg::CH_AUX:   state_nxt.aux_level      = code;
      default:            state_nxt = state;
    endcase
  end

endmodule

// ===== src/adc_channel_scan_conditioner.sv =====
// ADC channel scan conditioner: top level with input, state and result registers.
// Depends on acsc_pkg, acsc_if (channel interfaces) and acsc_cond.
//
// Usage:
//   in_ch  carries one signed converter sample per beat for the channel being
//          scanned (0 joystick X, 1 joystick Y, 2 battery, 3 auxiliary).
//   out_ch returns one result beat per sample: the channel just served, both
//          axes, filtered supply in mV, aux code and the start-conversion word
//          for the next channel.
//   cfg_ch writes deadband (index 0), new-sample weight (1) and battery floor
//          (2); other indexes are ignored. Write only while no sample is in flight.
// A sample is held in the input register, then passes through the conditioning
// logic into the result register, which drives the result beat.
// Throughput is one sample per cycle while the receiver takes results; the battery
// multiply-add in acsc_cond is the longest path.
// Reset (synchronous, rst_n low) empties both stages, restores the register
// defaults, sets the scan to channel 0, axes and aux to 0 and the filter to
// 12600 mV. When the receiver stalls, the result holds and the input register
// still takes one more sample before in_ch.ready drops.
module adc_channel_scan_conditioner (
  input  logic           clk,
  input  logic           rst_n,
  acsc_in_if.sink        in_ch,
  acsc_out_if.source     out_ch,
  acsc_cfg_if.sink       cfg_ch
);

  logic                                  in_vld_r;
  logic signed [acsc_pkg::SAMPLE_W-1:0]  sample_r;
  logic                                  out_vld_r;
  logic [acsc_pkg::CHAN_W-1:0]           scan_ch_r;
  logic [acsc_pkg::CHAN_W-1:0]           scan_ch_nxt;
  logic [acsc_pkg::CHAN_W-1:0]           done_ch_r;
  acsc_pkg::scan_state_t                 state_r;
  acsc_pkg::scan_state_t                 state_nxt;
  acsc_pkg::cfg_t                        cfg_r;
  logic                                  advance;

  // Move the held sample into the result register when that slot is free.
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;
  assign scan_ch_nxt  = scan_ch_r + 2'd1;

  acsc_cond u_cond (
    .sample    (sample_r),
    .channel   (scan_ch_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      sample_r <= in_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r                <= 1'b0;
      scan_ch_r                <= '0;
      done_ch_r                <= '0;
      state_r.axis_x           <= '0;
      state_r.axis_y           <= '0;
      state_r.battery_filter   <= acsc_pkg::FILT_RESET;
      state_r.aux_level        <= '0;
    end else begin
      if (advance) begin
        out_vld_r <= 1'b1;
        scan_ch_r <= scan_ch_nxt;
        done_ch_r <= scan_ch_r;
        state_r   <= state_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband         <= acsc_pkg::DBAND_RESET;
      cfg_r.new_weight       <= acsc_pkg::WEIGHT_RESET;
      cfg_r.battery_floor_mv <= acsc_pkg::FLOOR_RESET;
    end else if (cfg_ch.valid) begin
      case (acsc_pkg::cfg_idx_t'(cfg_ch.index))
        acsc_pkg::CFG_DEADBAND:   cfg_r.deadband         <= cfg_ch.data[acsc_pkg::DBAND_W-1:0];
        acsc_pkg::CFG_NEW_WEIGHT: cfg_r.new_weight       <= cfg_ch.data[acsc_pkg::WEIGHT_W-1:0];
        acsc_pkg::CFG_BATT_FLOOR: cfg_r.battery_floor_mv <= cfg_ch.data[acsc_pkg::MV_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Result fields come straight from the state registers.
  assign out_ch.valid        = out_vld_r;
  assign out_ch.channel_done = done_ch_r;
  assign out_ch.joy_x        = state_r.axis_x;
  assign out_ch.joy_y        = state_r.axis_y;
  assign out_ch.supply_mv    = state_r.battery_filter[acsc_pkg::FILT_W-1:8];
  assign out_ch.aux_code     = state_r.aux_level;
  assign out_ch.start_word   = acsc_pkg::START_BASE | {2'b00, scan_ch_r, 12'h000};

endmodule

// ===== src/acsc_checker.sv =====
// Port-level checks for the scan conditioner, bound to the top level.
// Depends on acsc_pkg for widths and the start-word base, and on the top level's channel interfaces.
module acsc_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [acsc_pkg::CHAN_W-1:0]          channel_done,
  input  logic signed [acsc_pkg::AXIS_W-1:0]   joy_x,
  input  logic [15:0]                          start_word
);

  logic [acsc_pkg::CHAN_W-1:0] exp_ch_r;

  // Track the channel the next result beat must report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ch_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_ch_r <= exp_ch_r + 2'd1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> channel_done == exp_ch_r)
    else $error("channel_done out of scan order");

  a_start_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> start_word == (acsc_pkg::START_BASE
                                 | {2'b00, 2'(channel_done + 2'd1), 12'h000}))
    else $error("start_word does not name the following channel");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (joy_x <= 8'sd100) && (joy_x >= -8'sd100))
    else $error("joy_x outside +/-100");

endmodule

bind adc_channel_scan_conditioner acsc_checker u_acsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .channel_done (out_ch.channel_done),
  .joy_x        (out_ch.joy_x),
  .start_word   (out_ch.start_word)
);
